>>> design/mixed_fraction_reducer_top_macros.svh
// Assertion macros shared by the mixed fraction reducer RTL.
`ifndef MIXED_FRACTION_REDUCER_TOP_MACROS_SVH
`define MIXED_FRACTION_REDUCER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfr assertion failed");

// Next-cycle implication, disabled during reset.
`define MFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfr assertion failed");

`endif

>>> design/mfr_pkg.sv
// Shared types and constants of the mixed fraction reducer.
package mfr_pkg;

   localparam int FIELD_WIDTH = 31;

   typedef logic [FIELD_WIDTH-1:0] field_type;

endpackage

>>> design/mixed_fraction_reducer_top.sv
// A zero denominator returns its result in the cycle after start.
// Otherwise the transaction runs a bit-serial divide, W = min(VALUE_WIDTH-1,
// 31) bits wide, then a binary gcd, then two more W-bit divides on the same
// one-bit-per-cycle divider. busy is high while the machine is out of IDLE
// (a zero denominator never raises it); one transaction at a time.
// Synchronous reset clears the state machine and the result strobe.
module mixed_fraction_reducer_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mfr_pkg::field_type req_whole_in,
   input  mfr_pkg::field_type req_numer_in,
   input  mfr_pkg::field_type req_denom_in,
   output logic               rsp_valid,
   output mfr_pkg::field_type rsp_whole_out,
   output mfr_pkg::field_type rsp_numer_out,
   output mfr_pkg::field_type rsp_denom_out,
   output logic               rsp_whole_overflow
);
   import mfr_pkg::*;
   `include "mixed_fraction_reducer_top_macros.svh"

   localparam int M  = VALUE_WIDTH - 1;
   localparam int DW = (M < FIELD_WIDTH) ? M : FIELD_WIDTH;
   localparam int CW = $clog2(DW);

   typedef enum logic [2:0] {
      IDLE,
      DIV_Q,
      GCD_TWO,
      GCD_LOOP,
      GCD_RESTORE,
      DIV_N,
      DIV_D
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ovf_ff, ovf_in;
   logic [DW-1:0]     whole_res_ff, whole_res_in;
   logic [DW-1:0]     numer_res_ff, numer_res_in;
   logic [DW-1:0]     denom_res_ff, denom_res_in;
   logic [DW-1:0]     div_rem_ff, div_rem_in;
   logic [DW-1:0]     div_quo_ff, div_quo_in;
   logic [CW-1:0]     div_cnt_ff, div_cnt_in;
   logic [DW-1:0]     a_ff, a_in;
   logic [DW-1:0]     b_ff, b_in;
   logic [CW-1:0]     k_ff, k_in;

   logic [DW:0]       trial;
   logic [DW:0]       diff;
   logic [DW-1:0]     divisor;
   logic              fits;
   logic [DW-1:0]     div_rem_step;
   logic [DW-1:0]     div_quo_step;
   logic              div_last;
   logic [DW:0]       sum;
   logic              sat;
   logic [DW-1:0]     a_minus_b;
   logic [DW-1:0]     b_minus_a;
   logic [DW-1:0]     denom_req;

   always_comb begin
      // one restoring-divide step: one quotient bit per cycle
      divisor      = (state_ff == DIV_Q) ? denom_res_ff : b_ff;
      trial        = {div_rem_ff, div_quo_ff[DW-1]};
      diff         = trial - {1'b0, divisor};
      fits         = !diff[DW];
      div_rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];
      div_quo_step = {div_quo_ff[DW-2:0], fits};
      div_last     = (div_cnt_ff == CW'(DW - 1));

      sum       = {1'b0, whole_res_ff} + {1'b0, div_quo_step};
      sat       = (M <= DW) && sum[DW];
      a_minus_b = a_ff - b_ff;
      b_minus_a = b_ff - a_ff;
      denom_req = DW'(req_denom_in);

      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      ovf_in       = ovf_ff;
      whole_res_in = whole_res_ff;
      numer_res_in = numer_res_ff;
      denom_res_in = denom_res_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;

      case (state_ff)
         IDLE: begin
            if (start) begin
               whole_res_in = DW'(req_whole_in);
               numer_res_in = DW'(req_numer_in);
               denom_res_in = denom_req;
               div_quo_in   = DW'(req_numer_in);
               div_rem_in   = '0;
               div_cnt_in   = '0;
               ovf_in       = 1'b0;
               if (denom_req == '0) begin
                  // pass everything through unchanged
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = DIV_Q;
               end
            end
         end
         DIV_Q: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + CW'(1);
            if (div_last) begin
               ovf_in       = sat;
               whole_res_in = sat ? '1 : sum[DW-1:0];
               numer_res_in = div_rem_step;
               a_in         = div_rem_step;
               b_in         = denom_res_ff;
               k_in         = '0;
               state_in     = GCD_TWO;
            end
         end
         GCD_TWO: begin
            // strip common factors of two, count them in k
            if (a_ff == '0) begin
               state_in = GCD_RESTORE;
            end else if (a_ff[0] || b_ff[0]) begin
               state_in = GCD_LOOP;
            end else begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + CW'(1);
            end
         end
         GCD_LOOP: begin
            if (a_ff == '0) begin
               state_in = GCD_RESTORE;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = a_minus_b >> 1;
            end else begin
               b_in = b_minus_a >> 1;
            end
         end
         GCD_RESTORE: begin
            // put back the common twos, then divide the remainder by the gcd
            if (k_ff == '0) begin
               div_quo_in = numer_res_ff;
               div_rem_in = '0;
               div_cnt_in = '0;
               state_in   = DIV_N;
            end else begin
               b_in = b_ff << 1;
               k_in = k_ff - CW'(1);
            end
         end
         DIV_N: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + CW'(1);
            if (div_last) begin
               numer_res_in = div_quo_step;
               div_quo_in   = denom_res_ff;
               div_rem_in   = '0;
               div_cnt_in   = '0;
               state_in     = DIV_D;
            end
         end
         DIV_D: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + CW'(1);
            if (div_last) begin
               denom_res_in = div_quo_step;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ovf_ff       <= ovf_in;
      whole_res_ff <= whole_res_in;
      numer_res_ff <= numer_res_in;
      denom_res_ff <= denom_res_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_cnt_ff   <= div_cnt_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
   end

   assign busy               = (state_ff != IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_whole_out      = FIELD_WIDTH'(whole_res_ff);
   assign rsp_numer_out      = FIELD_WIDTH'(numer_res_ff);
   assign rsp_denom_out      = FIELD_WIDTH'(denom_res_ff);
   assign rsp_whole_overflow = ovf_ff;

   `MFR_ASSERT_NEXT(a_zero_denom_bypass, clock, reset, start && !busy && (req_denom_in == '0), rsp_valid && !rsp_whole_overflow)
   `MFR_ASSERT_NOW(a_ovf_has_denom, clock, reset, rsp_valid && rsp_whole_overflow, rsp_denom_out != '0)
   `MFR_ASSERT_NOW(a_gcd_b_nonzero, clock, reset, (state_ff == GCD_LOOP) || (state_ff == GCD_RESTORE), b_ff != '0)
   `MFR_ASSERT_NOW(a_gcd_divisor_nonzero, clock, reset, (state_ff == DIV_N) || (state_ff == DIV_D), divisor != '0)

endmodule
